FILE: rtl/core/lant_pkg.sv
// ----------------------------------------------------------------------------
// lant_pkg
// Shared types, codes and widths for the ant stepper core.
// ----------------------------------------------------------------------------
`default_nettype none

package lant_pkg;

   localparam int LANT_MAX_WIDTH  = 64;
   localparam int LANT_MAX_HEIGHT = 64;

   localparam int CFG_W     = 7;
   localparam int FIELD_W   = 6;
   localparam int DIR_W     = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [CFG_W-1:0]   RST_GRID_WIDTH  = 7'd64;
   localparam logic [CFG_W-1:0]   RST_GRID_HEIGHT = 7'd64;
   localparam logic [FIELD_W-1:0] RST_START_X     = 6'd32;
   localparam logic [FIELD_W-1:0] RST_START_Y     = 6'd32;

   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

   typedef enum logic [1:0] {
      REQ_STEP    = 2'd0,
      REQ_READ    = 2'd1,
      REQ_RESTART = 2'd2
   } lant_req_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 3'd0,
      CSR_GRID_HEIGHT = 3'd1,
      CSR_START_X     = 3'd2,
      CSR_START_Y     = 3'd3,
      CSR_START_DIR   = 3'd4
   } lant_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_READ,
      ST_CLEAR
   } lant_state_type;

   typedef struct packed {
      logic accept;
      logic step_wb;
      logic read_wb;
      logic clear_wr;
      logic clear_last;
      logic clear_reply;
   } lant_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/core/lant_ram.sv
// ----------------------------------------------------------------------------
// lant_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lant_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lant_ctrl.sv
// ----------------------------------------------------------------------------
// lant_ctrl
// Request sequencer: step and read passes, grid clear sweep after reset and
// on restart.
// ----------------------------------------------------------------------------
`default_nettype none

module lant_ctrl import lant_pkg::*; #(
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [1:0]        req_type,
   output logic                   busy,
   output lant_ctrl_type          ctl,
   output logic      [ADDR_W-1:0] clr_addr
);

   lant_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              reply_ff, reply_in;
   logic              accept;
   logic              clr_last;

   assign accept   = start && (state_ff == ST_IDLE);
   assign clr_last = (state_ff == ST_CLEAR) && (clr_cnt_ff == {ADDR_W{1'b1}});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_STEP:    state_in = ST_STEP;
                  REQ_READ:    state_in = ST_READ;
                  REQ_RESTART: state_in = ST_CLEAR;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_STEP:  state_in = ST_IDLE;
         ST_READ:  state_in = ST_IDLE;
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      reply_in   = reply_ff;
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
      end
      if (accept && (req_type == REQ_RESTART)) begin
         reply_in = 1'b1;
      end
   end

   always_comb begin
      busy            = (state_ff != ST_IDLE);
      ctl.accept      = accept;
      ctl.step_wb     = (state_ff == ST_STEP);
      ctl.read_wb     = (state_ff == ST_READ);
      ctl.clear_wr    = (state_ff == ST_CLEAR);
      ctl.clear_last  = clr_last;
      ctl.clear_reply = reply_ff;
      clr_addr        = clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         reply_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         reply_ff   <= reply_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/langton_ant_stepper_core.sv
// ----------------------------------------------------------------------------
// langton_ant_stepper_core
// Langton's ant on a bounded one-bit grid held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a transfer happens at a clock edge with start high and
//   busy low. req_type selects step, read cell or restart; req_query_x/y
//   name the cell for a read.
//   Response channel: rsp_valid is high for one cycle per request, carrying
//   rsp_cell_value and the ant position and heading after the request.
//   The receiver cannot stall; each response is taken in its cycle.
//   Step and read: the RAM read is issued on the transfer edge; in the ST_STEP
//   or ST_READ state that follows, a step writes the cell back, and the
//   response is registered. busy drops while the strobe shows, so a new
//   request can be taken then, but not while the pass on the single grid RAM
//   port pair is still running.
//   Unknown request code: strobe registered on the transfer edge, busy stays low.
//   Restart: a clear sweep writes one cell per cycle over the whole RAM,
//   all 2**($clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)) cells (4096 by default),
//   then the start position is loaded and the response follows.
//   Reset: the same clear sweep runs with busy high and no response. csr_
//   writes must be made only while no request is in flight; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module langton_ant_stepper_core import lant_pkg::*; #(
   parameter int MAX_WIDTH  = LANT_MAX_WIDTH,
   parameter int MAX_HEIGHT = LANT_MAX_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_type,
   input  wire logic [FIELD_W-1:0]   req_query_x,
   input  wire logic [FIELD_W-1:0]   req_query_y,
   output logic                      rsp_valid,
   output logic                      rsp_cell_value,
   output logic      [FIELD_W-1:0]   rsp_ant_x,
   output logic      [FIELD_W-1:0]   rsp_ant_y,
   output logic      [DIR_W-1:0]     rsp_ant_dir,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wr_data
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int CH     = $clog2(MAX_HEIGHT);
   localparam int EW     = $clog2(MAX_WIDTH + 1);
   localparam int EH     = $clog2(MAX_HEIGHT + 1);
   localparam int ADDR_W = CW + CH;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int XXW    = (EW > CFG_W) ? EW : CFG_W;
   localparam int XYW    = (EH > CFG_W) ? EH : CFG_W;
   localparam int SXW    = (EW > FIELD_W) ? EW : FIELD_W;
   localparam int SYW    = (EH > FIELD_W) ? EH : FIELD_W;

   lant_ctrl_type     ctl;
   logic [ADDR_W-1:0] clr_addr;

   logic [CFG_W-1:0]   grid_width_ff, grid_height_ff;
   logic [FIELD_W-1:0] start_x_ff, start_y_ff;
   logic [DIR_W-1:0]   start_dir_ff;

   logic [CW-1:0]    pos_x_ff, pos_x_in;
   logic [CH-1:0]    pos_y_ff, pos_y_in;
   logic [DIR_W-1:0] dir_ff, dir_in;
   logic [CW-1:0]    cur_x_ff, cur_x_in;
   logic [CH-1:0]    cur_y_ff, cur_y_in;
   logic             qin_ff, qin_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_cell_ff, rsp_cell_in;
   logic [FIELD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [DIR_W-1:0]   rsp_dir_ff;

   logic [XXW-1:0] wide_w;
   logic [XYW-1:0] wide_h;
   logic [EW-1:0]  eff_w;
   logic [EH-1:0]  eff_h;
   logic [CW-1:0]  clamp_x, home_x;
   logic [CH-1:0]  clamp_y, home_y;
   logic           start_out;

   logic              ram_we, ram_wd, ram_re, ram_rd;
   logic [ADDR_W-1:0] ram_wa, ram_ra;
   logic              new_cell;
   logic [DIR_W-1:0]  turn_dir;

   lant_ctrl #(
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .ctl      (ctl),
      .clr_addr (clr_addr)
   );

   lant_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= RST_GRID_WIDTH;
         grid_height_ff <= RST_GRID_HEIGHT;
         start_x_ff     <= RST_START_X;
         start_y_ff     <= RST_START_Y;
         start_dir_ff   <= DIR_UP;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wr_data;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wr_data;
            CSR_START_X:     start_x_ff     <= csr_wr_data[FIELD_W-1:0];
            CSR_START_Y:     start_y_ff     <= csr_wr_data[FIELD_W-1:0];
            CSR_START_DIR:   start_dir_ff   <= csr_wr_data[DIR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      wide_w = XXW'(grid_width_ff);
      wide_h = XYW'(grid_height_ff);
      if (wide_w == '0) begin
         eff_w = EW'(1);
      end else if (wide_w > XXW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(wide_w);
      end
      if (wide_h == '0) begin
         eff_h = EH'(1);
      end else if (wide_h > XYW'(MAX_HEIGHT)) begin
         eff_h = EH'(MAX_HEIGHT);
      end else begin
         eff_h = EH'(wide_h);
      end
   end

   always_comb begin
      clamp_x = (EW'(pos_x_ff) >= eff_w) ? CW'(eff_w - EW'(1)) : pos_x_ff;
      clamp_y = (EH'(pos_y_ff) >= eff_h) ? CH'(eff_h - EH'(1)) : pos_y_ff;
      start_out = (SXW'(start_x_ff) >= SXW'(eff_w)) || (SYW'(start_y_ff) >= SYW'(eff_h));
      home_x = start_out ? CW'(eff_w >> 1) : CW'(start_x_ff);
      home_y = start_out ? CH'(eff_h >> 1) : CH'(start_y_ff);
      qin_in = (SXW'(req_query_x) < SXW'(eff_w)) && (SYW'(req_query_y) < SYW'(eff_h));
   end

   // Latch the cell under the ant for the write-back pass.
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (ctl.accept) begin
         cur_x_in = clamp_x;
         cur_y_in = clamp_y;
      end
   end

   always_comb begin
      ram_re = ctl.accept;
      if (req_type == REQ_STEP) begin
         ram_ra = {clamp_y, clamp_x};
      end else begin
         ram_ra = {CH'(req_query_y), CW'(req_query_x)};
      end
      new_cell = ~ram_rd;
      ram_we   = ctl.clear_wr || ctl.step_wb;
      ram_wa   = ctl.clear_wr ? clr_addr : {cur_y_ff, cur_x_ff};
      ram_wd   = ctl.clear_wr ? 1'b0 : new_cell;
      turn_dir = ram_rd ? (dir_ff - DIR_W'(1)) : (dir_ff + DIR_W'(1));
   end

   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      dir_in       = dir_ff;
      rsp_valid_in = 1'b0;
      rsp_cell_in  = 1'b0;
      if (ctl.step_wb) begin
         pos_x_in     = cur_x_ff;
         pos_y_in     = cur_y_ff;
         dir_in       = turn_dir;
         rsp_valid_in = 1'b1;
         rsp_cell_in  = new_cell;
         case (turn_dir)
            DIR_UP: begin
               if (cur_y_ff != '0) pos_y_in = cur_y_ff - CH'(1);
            end
            DIR_RIGHT: begin
               if (EW'(cur_x_ff) != eff_w - EW'(1)) pos_x_in = cur_x_ff + CW'(1);
            end
            DIR_DOWN: begin
               if (EH'(cur_y_ff) != eff_h - EH'(1)) pos_y_in = cur_y_ff + CH'(1);
            end
            default: begin
               if (cur_x_ff != '0) pos_x_in = cur_x_ff - CW'(1);
            end
         endcase
      end else if (ctl.read_wb) begin
         rsp_valid_in = 1'b1;
         rsp_cell_in  = ram_rd && qin_ff;
      end else if (ctl.clear_last) begin
         pos_x_in     = home_x;
         pos_y_in     = home_y;
         dir_in       = start_dir_ff;
         rsp_valid_in = ctl.clear_reply;
      end else if (ctl.accept && (req_type != REQ_STEP) && (req_type != REQ_READ)
                   && (req_type != REQ_RESTART)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      dir_ff      <= dir_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_x_ff    <= FIELD_W'(pos_x_in);
      rsp_y_ff    <= FIELD_W'(pos_y_in);
      rsp_dir_ff  <= dir_in;
      if (ctl.accept) begin
         qin_ff <= qin_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_ant_x      = rsp_x_ff;
   assign rsp_ant_y      = rsp_y_ff;
   assign rsp_ant_dir    = rsp_dir_ff;

endmodule

`default_nettype wire
